// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the ray-sphere intersection RTL.
// Depends on nothing; files that check their own logic include it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising aclk edge once reset is released.
`define RSI_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Check on every rising aclk edge, reset included.
`define RSI_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== rtl/rsi_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, widths, register indexes and helpers for the ray-sphere block.
// No dependencies; imported by every module of the block.
package rsi_pkg;

    // Q16.16 fixed point throughout; the internal widths below follow from it
    localparam int FRAC_BITS = 16;
    localparam int B_W       = 38;  // b = -(P.D) >> FRAC_BITS
    localparam int REM_W     = 76;  // discriminant magnitude, 2*FRAC_BITS fraction
    localparam int ROOT_W    = 39;  // square root of the discriminant

    // Configuration register indexes
    localparam logic [2:0] REG_CENTER_X = 3'd0;
    localparam logic [2:0] REG_CENTER_Y = 3'd1;
    localparam logic [2:0] REG_CENTER_Z = 3'd2;
    localparam logic [2:0] REG_RADIUS   = 3'd3;
    localparam logic [2:0] REG_EPSILON  = 3'd4;

    typedef struct packed {
        logic [2:0][31:0] c;    // sphere center, signed
        logic [30:0]      rad;
        logic [15:0]      eps;
    } cfg_t;

    typedef struct packed {
        logic [2:0][31:0] o;    // origin, signed
        logic [2:0][17:0] d;    // direction, signed
        logic [30:0]      maxd;
    } ray_t;

    // Item that travels through the square-root pipeline
    typedef struct packed {
        ray_t                   ray;
        logic signed [B_W-1:0]  b;
        logic                   miss;
    } tag_t;

    typedef struct packed {
        logic             hit;
        logic             is_in;
        logic [30:0]      t_dist;
        logic [2:0][31:0] pt;
        logic [2:0][31:0] nr;
    } res_t;

    // Clamp to the signed 32-bit range
    function automatic logic [31:0] sat32(input logic signed [34:0] v);
        if (v > 35'sd2147483647) begin
            return 32'h7fff_ffff;
        end else if (v < -35'sd2147483648) begin
            return 32'h8000_0000;
        end else begin
            return v[31:0];
        end
    endfunction

endpackage

// ===== rtl/rsi_front.sv =====
`timescale 1ns / 1ps
// Front pipeline: offset, dot product, b, |P|^2 and discriminant (five stages).
// Depends on rsi_pkg.
module rsi_front import rsi_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              ce,
    input  logic              in_valid,
    input  ray_t              in_ray,
    input  cfg_t              cfg,
    output logic              out_valid,
    output tag_t              out_tag,
    output logic [REM_W-1:0]  out_rem
);

    // Stage 1: P = O - C
    logic                    v1_reg;
    ray_t                    ray1_reg;
    logic signed [32:0]      p1_reg [3];
    // Stage 2: products
    logic                    v2_reg;
    ray_t                    ray2_reg;
    logic signed [50:0]      pd2_reg [3];
    logic [65:0]             sq2_reg [3];
    // Stage 3: b and |P|^2
    logic                    v3_reg;
    ray_t                    ray3_reg;
    logic signed [B_W-1:0]   b3_reg;
    logic [66:0]             psum3_reg;
    // Stage 4: partial products of b^2, r^2
    logic                    v4_reg;
    ray_t                    ray4_reg;
    logic signed [B_W-1:0]   b4_reg;
    logic [66:0]             psum4_reg;
    logic [63:0]             ll4_reg;
    logic [37:0]             hl4_reg;
    logic [11:0]             hh4_reg;
    logic [61:0]             r24_reg;
    // Stage 5 (outputs)
    logic                    v5_reg;
    tag_t                    tag5_reg;
    logic [REM_W-1:0]        rem5_reg;

    logic signed [52:0]      dot;
    logic signed [53:0]      ndot;
    logic [B_W-1:0]          mb;
    logic [REM_W-1:0]        b2;
    logic [REM_W:0]          disc;
    logic [REM_W:0]          epsw;
    logic                    miss_next;

    always_comb begin
        dot  = 53'(pd2_reg[0]) + 53'(pd2_reg[1]) + 53'(pd2_reg[2]);
        ndot = -54'(dot);
        mb   = b3_reg[B_W-1] ? B_W'(-b3_reg) : B_W'(b3_reg);
        b2   = REM_W'(ll4_reg) + (REM_W'(hl4_reg) << 33) + (REM_W'(hh4_reg) << 64);
        disc = {1'b0, b2} - (REM_W+1)'(psum4_reg) + (REM_W+1)'(r24_reg);
        epsw = (REM_W+1)'(cfg.eps) << FRAC_BITS;
        miss_next = disc[REM_W] || (disc < epsw);
    end

    // Valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else if (ce) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    // Datapath; advance all stages together
    always_ff @(posedge aclk) begin
        if (ce) begin
            ray1_reg <= in_ray;
            ray2_reg <= ray1_reg;
            ray3_reg <= ray2_reg;
            ray4_reg <= ray3_reg;
            for (int i = 0; i < 3; i++) begin
                p1_reg[i]  <= 33'(signed'(in_ray.o[i])) - 33'(signed'(cfg.c[i]));
                pd2_reg[i] <= p1_reg[i] * 51'(signed'(ray1_reg.d[i]));
                sq2_reg[i] <= 66'(p1_reg[i] * p1_reg[i]);
            end
            b3_reg    <= ndot[53:FRAC_BITS];
            psum3_reg <= 67'(sq2_reg[0]) + 67'(sq2_reg[1]) + 67'(sq2_reg[2]);
            b4_reg    <= b3_reg;
            psum4_reg <= psum3_reg;
            ll4_reg   <= mb[31:0] * mb[31:0];
            hl4_reg   <= mb[37:32] * mb[31:0];
            hh4_reg   <= mb[37:32] * mb[37:32];
            r24_reg   <= cfg.rad * cfg.rad;
            tag5_reg.ray  <= ray4_reg;
            tag5_reg.b    <= b4_reg;
            tag5_reg.miss <= miss_next;
            rem5_reg      <= miss_next ? '0 : disc[REM_W-1:0];
        end
    end

    assign out_valid = v5_reg;
    assign out_tag   = tag5_reg;
    assign out_rem   = rem5_reg;

endmodule

// ===== rtl/rsi_sqrt.sv =====
`timescale 1ns / 1ps
// Integer square root, one result bit per pipeline stage, tag carried alongside.
// Depends on rsi_pkg.
module rsi_sqrt import rsi_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               ce,
    input  logic               in_valid,
    input  tag_t               in_tag,
    input  logic [REM_W-1:0]   in_rem,
    output logic               out_valid,
    output tag_t               out_tag,
    output logic [ROOT_W-1:0]  out_root
);

    logic              v_reg    [ROOT_W];
    tag_t              tag_reg  [ROOT_W];
    logic [REM_W-1:0]  rem_reg  [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W];

    for (genvar j = 0; j < ROOT_W; j++) begin : g_bit
        localparam int K = ROOT_W - 1 - j;
        logic              v_src;
        tag_t              tag_src;
        logic [REM_W-1:0]  rem_src;
        logic [ROOT_W-1:0] root_src;
        logic [REM_W+1:0]  trial;
        logic              take;

        if (j == 0) begin : g_first
            assign v_src    = in_valid;
            assign tag_src  = in_tag;
            assign rem_src  = in_rem;
            assign root_src = '0;
        end else begin : g_next
            assign v_src    = v_reg[j-1];
            assign tag_src  = tag_reg[j-1];
            assign rem_src  = rem_reg[j-1];
            assign root_src = root_reg[j-1];
        end

        // (r + 2^k)^2 - r^2 = r*2^(k+1) + 2^(2k)
        assign trial = ((REM_W+2)'(root_src) << (K + 1)) + ((REM_W+2)'(1) << (2 * K));
        assign take  = (REM_W+2)'(rem_src) >= trial;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[j] <= 1'b0;
            end else if (ce) begin
                v_reg[j] <= v_src;
            end
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                tag_reg[j]  <= tag_src;
                rem_reg[j]  <= take ? rem_src - trial[REM_W-1:0] : rem_src;
                root_reg[j] <= take ? (root_src | (ROOT_W'(1) << K)) : root_src;
            end
        end
    end

    assign out_valid = v_reg[ROOT_W-1];
    assign out_tag   = tag_reg[ROOT_W-1];
    assign out_root  = root_reg[ROOT_W-1];

endmodule

// ===== rtl/rsi_back.sv =====
`timescale 1ns / 1ps
// Back pipeline: root choice, hit point, normal; last stage is the output register.
// Depends on rsi_pkg.
module rsi_back import rsi_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               ce,
    input  logic               in_valid,
    input  tag_t               in_tag,
    input  logic [ROOT_W-1:0]  in_root,
    input  cfg_t               cfg,
    output logic               out_valid,
    output res_t               out_res
);

    // Root choice
    logic signed [39:0] bx, sx, x1, x2, ex, dsel;
    logic               near, miss_r;

    always_comb begin
        bx   = 40'(in_tag.b);
        sx   = 40'(in_root);
        ex   = 40'(cfg.eps);
        x1   = bx - sx;
        x2   = bx + sx;
        near = x1 > ex;
        dsel = near ? x1 : x2;
        miss_r = in_tag.miss || (x2 < ex) || (dsel > 40'(in_tag.ray.maxd));
    end

    logic               vr_reg, vm_reg, vp_reg, vn_reg;
    logic               missr_reg, missm_reg, missp_reg;
    logic               insr_reg, insm_reg, insp_reg;
    logic [30:0]        distr_reg, distm_reg, distp_reg;
    ray_t               rayr_reg, raym_reg;
    logic signed [49:0] prod_reg [3];
    logic [31:0]        pt_reg   [3];
    res_t               res_reg;
    res_t               res_next;

    logic signed [33:0] step   [3];
    logic signed [34:0] ptsum  [3];
    logic signed [32:0] diff   [3];
    logic signed [33:0] nsign  [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            step[i]  = prod_reg[i][49:FRAC_BITS];
            ptsum[i] = 35'(signed'(raym_reg.o[i])) + 35'(step[i]);
            diff[i]  = 33'(signed'(pt_reg[i])) - 33'(signed'(cfg.c[i]));
            nsign[i] = insp_reg ? -34'(diff[i]) : 34'(diff[i]);
        end
        res_next = '0;
        if (!missp_reg) begin
            res_next.hit    = 1'b1;
            res_next.is_in  = insp_reg;
            res_next.t_dist = distp_reg;
            for (int i = 0; i < 3; i++) begin
                res_next.pt[i] = pt_reg[i];
                res_next.nr[i] = sat32(35'(nsign[i]));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vr_reg <= 1'b0;
            vm_reg <= 1'b0;
            vp_reg <= 1'b0;
            vn_reg <= 1'b0;
        end else if (ce) begin
            vr_reg <= in_valid;
            vm_reg <= vr_reg;
            vp_reg <= vm_reg;
            vn_reg <= vp_reg;
        end
    end

    // Hold everything while the output item waits
    always_ff @(posedge aclk) begin
        if (ce) begin
            missr_reg <= miss_r;
            insr_reg  <= !near;
            distr_reg <= dsel[30:0];
            rayr_reg  <= in_tag.ray;
            missm_reg <= missr_reg;
            insm_reg  <= insr_reg;
            distm_reg <= distr_reg;
            raym_reg  <= rayr_reg;
            missp_reg <= missm_reg;
            insp_reg  <= insm_reg;
            distp_reg <= distm_reg;
            for (int i = 0; i < 3; i++) begin
                prod_reg[i] <= 50'(signed'({1'b0, distr_reg})) * 50'(signed'(rayr_reg.d[i]));
                pt_reg[i]   <= sat32(ptsum[i]);
            end
            res_reg <= res_next;
        end
    end

    assign out_valid = vn_reg;
    assign out_res   = res_reg;

endmodule

// ===== rtl/ray_sphere_intersect.sv =====
`timescale 1ns / 1ps
// Ray-sphere intersection, Q16.16. One ray in per cycle, one result out per ray,
// in order. Pipeline: 5 front stages (offset, dot product, squares, discriminant),
// 39 square-root stages (one root bit each) and 4 back stages (root choice, step
// along the ray, hit point, normal into the output register). The pipeline advances
// when the output register is empty or taken, so s_tready follows m_tready.
// Configuration must be written only while no ray is in flight (not enforced).
// Depends on rsi_pkg, rsi_front, rsi_sqrt, rsi_back and assert_macros.svh.
`include "assert_macros.svh"
module ray_sphere_intersect import rsi_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    // Configuration write port
    input  logic          cfg_we,
    input  logic [2:0]    cfg_index,
    input  logic [31:0]   cfg_wdata,
    // Rays
    input  logic          s_tvalid,
    output logic          s_tready,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, max_distance, zero pad
    input  logic [183:0]  s_tdata,
    // Results
    output logic          m_tvalid,
    input  logic          m_tready,
    // distance, point_x, point_y, point_z, normal_x, normal_y, normal_z, zero pad
    output logic [223:0]  m_tdata,
    // hit, inside_res
    output logic [1:0]    m_tuser
);

    cfg_t cfg_reg;

    // Register writes; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.c   <= '0;
            cfg_reg.rad <= 31'd65536;
            cfg_reg.eps <= 16'd7;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_CENTER_X: cfg_reg.c[0] <= cfg_wdata;
                REG_CENTER_Y: cfg_reg.c[1] <= cfg_wdata;
                REG_CENTER_Z: cfg_reg.c[2] <= cfg_wdata;
                REG_RADIUS:   cfg_reg.rad  <= cfg_wdata[30:0];
                REG_EPSILON:  cfg_reg.eps  <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    logic ce;
    ray_t ray_in;
    assign ce       = !m_tvalid || m_tready;
    assign s_tready = ce;

    always_comb begin
        ray_in.o[0] = s_tdata[31:0];
        ray_in.o[1] = s_tdata[63:32];
        ray_in.o[2] = s_tdata[95:64];
        ray_in.d[0] = s_tdata[113:96];
        ray_in.d[1] = s_tdata[131:114];
        ray_in.d[2] = s_tdata[149:132];
        ray_in.maxd = s_tdata[180:150];
    end

    logic              f_valid, q_valid;
    tag_t              f_tag, q_tag;
    logic [REM_W-1:0]  f_rem;
    logic [ROOT_W-1:0] q_root;
    res_t              res;

    rsi_front u_front (
        .aclk(aclk), .aresetn(aresetn), .ce(ce),
        .in_valid(s_tvalid), .in_ray(ray_in), .cfg(cfg_reg),
        .out_valid(f_valid), .out_tag(f_tag), .out_rem(f_rem)
    );

    rsi_sqrt u_sqrt (
        .aclk(aclk), .aresetn(aresetn), .ce(ce),
        .in_valid(f_valid), .in_tag(f_tag), .in_rem(f_rem),
        .out_valid(q_valid), .out_tag(q_tag), .out_root(q_root)
    );

    rsi_back u_back (
        .aclk(aclk), .aresetn(aresetn), .ce(ce),
        .in_valid(q_valid), .in_tag(q_tag), .in_root(q_root), .cfg(cfg_reg),
        .out_valid(m_tvalid), .out_res(res)
    );

    // Pack the result item
    assign m_tuser = {res.is_in, res.hit};
    assign m_tdata = {1'b0, res.nr[2], res.nr[1], res.nr[0],
                      res.pt[2], res.pt[1], res.pt[0], res.t_dist};

    `RSI_ASSERT(a_miss_zero, m_tvalid && !m_tuser[0] |-> m_tdata == '0 && !m_tuser[1],
        "missed ray carries nonzero result fields")
    `RSI_ASSERT(a_inside_hit, m_tvalid && m_tuser[1] |-> m_tuser[0],
        "inside flag without a hit")
    `RSI_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_tvalid,
        "result valid right after reset")

endmodule

// ===== verif/ray_sphere_intersect_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for ray_sphere_intersect: streams rays, predicts each
// hit record in fixed point and compares it field by field. Depends on rsi_pkg.
module ray_sphere_intersect_tb;
    import rsi_pkg::*;

    localparam int PIPE_LAT = 48;

    typedef struct {
        logic [31:0] o [3];
        logic [17:0] d [3];
        logic [30:0] maxd;
    } ray_item_t;

    typedef struct {
        logic        hit;
        logic        is_in;
        logic [30:0] t_dist;
        logic [31:0] pt [3];
        logic [31:0] nr [3];
    } hit_rec_t;

    logic          aclk;
    logic          aresetn;
    logic          cfg_we;
    logic [2:0]    cfg_index;
    logic [31:0]   cfg_wdata;
    logic          s_tvalid;
    logic          s_tready;
    logic [183:0]  s_tdata;
    logic          m_tvalid;
    logic          m_tready;
    logic [223:0]  m_tdata;
    logic [1:0]    m_tuser;

    ray_sphere_intersect dut (.*);

    // Model copy of the sphere registers
    logic signed [31:0] sph_c [3];
    logic [30:0]        sph_rad;
    logic [15:0]        sph_eps;

    ray_item_t ray_q [$];
    hit_rec_t  hit_q [$];
    int        n_mismatch;
    int        tx_idle_pct;
    int        rx_idle_pct;
    logic      have_item;
    logic      in_taken;
    ray_item_t cur_ray;

    // Predict the hit record of one ray against the current sphere
    function automatic hit_rec_t predict_hit(ray_item_t r);
        hit_rec_t h;
        logic signed [127:0] o [3], d [3], c [3], p [3];
        logic signed [127:0] dotp, b, disc, s, x1, x2, hdist, pt, nr, t, epsw;
        logic is_in;
        h.hit = 0; h.is_in = 0; h.t_dist = 0;
        dotp = 0;
        for (int i = 0; i < 3; i++) begin
            h.pt[i] = 0; h.nr[i] = 0;
            o[i] = $signed(r.o[i]);
            d[i] = $signed(r.d[i]);
            c[i] = sph_c[i];
            p[i] = o[i] - c[i];
            dotp += p[i] * d[i];
        end
        b = (-dotp) >>> FRAC_BITS;
        disc = b * b - p[0] * p[0] - p[1] * p[1] - p[2] * p[2]
             + $signed({97'd0, sph_rad}) * $signed({97'd0, sph_rad});
        epsw = $signed({112'd0, sph_eps}) <<< FRAC_BITS;
        if (disc < epsw) return h;
        // Bitwise floor square root
        s = 0;
        for (int k = 38; k >= 0; k--) begin
            t = s | (128'sd1 <<< k);
            if (t * t <= disc) s = t;
        end
        x1 = b - s;
        x2 = b + s;
        if (x2 < $signed({112'd0, sph_eps})) return h;
        if (x1 > $signed({112'd0, sph_eps})) begin
            hdist = x1; is_in = 0;
        end else begin
            hdist = x2; is_in = 1;
        end
        if (hdist > $signed({97'd0, r.maxd})) return h;
        for (int i = 0; i < 3; i++) begin
            pt = o[i] + ((hdist * d[i]) >>> FRAC_BITS);
            if (pt > 128'sd2147483647) pt = 128'sd2147483647;
            if (pt < -128'sd2147483648) pt = -128'sd2147483648;
            nr = pt - c[i];
            if (is_in) nr = -nr;
            if (nr > 128'sd2147483647) nr = 128'sd2147483647;
            if (nr < -128'sd2147483648) nr = -128'sd2147483648;
            h.pt[i] = pt[31:0];
            h.nr[i] = nr[31:0];
        end
        h.hit = 1;
        h.is_in = is_in;
        h.t_dist = hdist[30:0];
        return h;
    endfunction

    // Field-by-field comparison of two hit records
    function automatic bit rec_equal(hit_rec_t x, hit_rec_t y);
        bit eq;
        eq = (x.hit === y.hit) && (x.is_in === y.is_in) && (x.t_dist === y.t_dist);
        for (int i = 0; i < 3; i++) begin
            if (x.pt[i] !== y.pt[i] || x.nr[i] !== y.nr[i]) eq = 0;
        end
        return eq;
    endfunction

    function automatic logic [183:0] pack_ray(ray_item_t r);
        return {3'd0, r.maxd, r.d[2], r.d[1], r.d[0], r.o[2], r.o[1], r.o[0]};
    endfunction

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    // Drive rays on the falling edge; hold the current item until taken
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 0;
            have_item = 0;
        end else begin
            if (in_taken) have_item = 0;
            if (!have_item && ray_q.size() > 0 &&
                    $urandom_range(99, 0) >= tx_idle_pct) begin
                cur_ray = ray_q.pop_front();
                have_item = 1;
                hit_q.push_back(predict_hit(cur_ray));
            end
            s_tvalid <= have_item;
            if (have_item) s_tdata <= pack_ray(cur_ray);
            m_tready <= ($urandom_range(99, 0) >= rx_idle_pct);
        end
    end

    // Note input acceptance and check results on the rising edge
    always @(posedge aclk) begin
        in_taken <= aresetn && s_tvalid && s_tready;
        if (aresetn && m_tvalid && m_tready) begin
            hit_rec_t e, a;
            a.hit = m_tuser[0];
            a.is_in = m_tuser[1];
            a.t_dist = m_tdata[30:0];
            for (int i = 0; i < 3; i++) begin
                a.pt[i] = m_tdata[31 + 32*i +: 32];
                a.nr[i] = m_tdata[127 + 32*i +: 32];
            end
            if (hit_q.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10) $display("unexpected result item %h", m_tdata);
            end else begin
                e = hit_q.pop_front();
                if (!rec_equal(e, a)) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("mismatch: exp hit=%0d in=%0d d=%h pt=%h %h %h nr=%h %h %h\n"
                                 , e.hit, e.is_in, e.t_dist, e.pt[0], e.pt[1], e.pt[2]
                                 , e.nr[0], e.nr[1], e.nr[2]
                                 , "          got hit=%0d in=%0d d=%h pt=%h %h %h nr=%h %h %h"
                                 , a.hit, a.is_in, a.t_dist, a.pt[0], a.pt[1], a.pt[2]
                                 , a.nr[0], a.nr[1], a.nr[2]);
                end
            end
        end
    end

    // Write one sphere register at the falling edge
    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        @(negedge aclk);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we <= 0;
        case (idx)
            REG_CENTER_X: sph_c[0] = val;
            REG_CENTER_Y: sph_c[1] = val;
            REG_CENTER_Z: sph_c[2] = val;
            REG_RADIUS:   sph_rad = val[30:0];
            REG_EPSILON:  sph_eps = val[15:0];
            default: ;
        endcase
    endtask

    task automatic set_sphere(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                              logic [31:0] rad, logic [31:0] eps);
        write_reg(REG_CENTER_X, cx);
        write_reg(REG_CENTER_Y, cy);
        write_reg(REG_CENTER_Z, cz);
        write_reg(REG_RADIUS, rad);
        write_reg(REG_EPSILON, eps);
    endtask

    // Wait until every queued ray has been answered, then let the pipe drain
    task automatic drain;
        while (ray_q.size() > 0 || have_item || hit_q.size() > 0) @(posedge aclk);
        repeat (PIPE_LAT + 5) @(posedge aclk);
    endtask

    // Small direction component, sometimes an extreme
    function automatic logic [17:0] rand_dir();
        case ($urandom_range(9, 0))
            0: return 18'sd65536;
            1: return -18'sd65536;
            2: return 18'($urandom());
            default: return 18'($urandom_range(131072, 0) - 65536);
        endcase
    endfunction

    // Ray aimed at the sphere: origin near the center, direction mostly toward it
    function automatic ray_item_t aimed_ray(int spread);
        ray_item_t r;
        int ax;
        ax = $urandom_range(2, 0);
        for (int i = 0; i < 3; i++) begin
            r.o[i] = sph_c[i] + $signed($urandom_range(2 * spread, 0) - spread);
            r.d[i] = 18'($urandom_range(8000, 0) - 4000);
        end
        r.d[ax] = ($signed(r.o[ax] - sph_c[ax]) > 0) ? -18'sd65000 : 18'sd65000;
        if ($urandom_range(3, 0) == 0) r.d[ax] = -r.d[ax];
        r.maxd = ($urandom_range(4, 0) == 0) ? 31'($urandom())
                                             : 31'h7fff_ffff - 31'($urandom_range(9, 0));
        if ($urandom_range(5, 0) == 0) r.maxd = 31'($urandom_range(4 * spread, 0));
        return r;
    endfunction

    function automatic ray_item_t noise_ray();
        ray_item_t r;
        for (int i = 0; i < 3; i++) begin
            r.o[i] = $urandom();
            r.d[i] = rand_dir();
        end
        r.maxd = 31'($urandom());
        return r;
    endfunction

    task automatic random_phase(int n, int spread);
        for (int k = 0; k < n; k++)
            ray_q.push_back(($urandom_range(9, 0) < 8) ? aimed_ray(spread) : noise_ray());
        drain();
    endtask

    initial begin
        ray_item_t r;
        n_mismatch = 0;
        have_item = 0;
        in_taken = 0;
        tx_idle_pct = 38;
        rx_idle_pct = 74;
        aresetn = 0;
        cfg_we = 0;
        cfg_index = REG_CENTER_X;
        cfg_wdata = 0;
        s_tvalid = 0;
        s_tdata = 0;
        m_tready = 0;
        sph_c[0] = 0; sph_c[1] = 0; sph_c[2] = 0;
        sph_rad = 65536;
        sph_eps = 7;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;

        // Directed: reset sphere, outside hit, inside hit, miss, range cut,
        // tangent, non-unit direction and saturating points
        r.o = '{32'hfffd_0000, 0, 0}; r.d = '{18'sd65536, 0, 0}; r.maxd = 31'h7fff_ffff;
        ray_q.push_back(r);
        r.o = '{0, 0, 0}; ray_q.push_back(r);
        r.o = '{32'hfffd_0000, 32'h0002_0000, 0}; ray_q.push_back(r);
        r.o = '{32'hfffd_0000, 0, 0}; r.maxd = 31'h0001_0000; ray_q.push_back(r);
        r.maxd = 0; ray_q.push_back(r);
        r.o = '{32'hfffd_0000, 32'h0001_0000, 0}; r.maxd = 31'h7fff_ffff; ray_q.push_back(r);
        r.o = '{32'h0003_0000, 0, 0}; ray_q.push_back(r);
        r.o = '{32'hfffd_0000, 0, 0}; r.d = '{-18'sd65536, 0, 0}; ray_q.push_back(r);
        r.d = '{18'sd131071, 18'sd131071, 18'h2_0000}; ray_q.push_back(r);
        r.o = '{32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000}; r.d = '{0, 0, 0};
        ray_q.push_back(r);
        r.d = '{18'sd65536, -18'sd65536, 18'sd65536}; ray_q.push_back(r);
        r.o = '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff};
        r.d = '{18'sd65536, 18'sd65536, 18'sd65536}; ray_q.push_back(r);
        drain();

        // Huge sphere near the +x, +y, -z corner, zero epsilon; points saturate
        set_sphere(32'h7fff_0000, 32'h7fff_0000, 32'h8001_0000, 32'h7fff_ffff, 0);
        r.o = '{32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000};
        r.d = '{18'sd65536, 0, 0}; r.maxd = 31'h7fff_ffff; ray_q.push_back(r);
        r.d = '{-18'sd65536, 18'sd65536, -18'sd65536}; ray_q.push_back(r);
        r.o = '{0, 0, 0}; r.d = '{18'sd65536, 18'sd65536, -18'sd65536}; ray_q.push_back(r);
        random_phase(30, 32'h4000_0000);

        // Zero radius and the largest epsilon
        set_sphere(0, 0, 0, 0, 32'h0000_ffff);
        random_phase(20, 32'h0008_0000);

        // Main random phases with three idling patterns
        set_sphere(32'h0010_0000, 32'hfff0_0000, 32'h0003_8000, 32'h0004_0000, 7);
        random_phase(500, 32'h0010_0000);
        tx_idle_pct = 74;
        rx_idle_pct = 38;
        set_sphere($urandom(), $urandom(), $urandom(), $urandom_range(32'h00ff_ffff, 0),
                   $urandom_range(65535, 0));
        random_phase(500, 32'h0100_0000);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        set_sphere(32'hffff_0000, 32'h0000_8000, 32'h8000_0000, 32'h0000_0100, 1);
        random_phase(500, 32'h0000_0400);

        if (n_mismatch == 0) begin
            $display("[ray_sphere_intersect] OK");
        end else begin
            $display("[ray_sphere_intersect] ERROR");
        end
        $finish;
    end

    // Unexpected items are caught above; left-over expectations hang drain; stop a hang
    initial begin
        #20ms;
        $display("[ray_sphere_intersect] ERROR");
        $finish;
    end

endmodule

// ===== ray_sphere_intersect.f =====
+incdir+rtl
rtl/rsi_pkg.sv
rtl/rsi_front.sv
rtl/rsi_sqrt.sv
rtl/rsi_back.sv
rtl/ray_sphere_intersect.sv
verif/ray_sphere_intersect_tb.sv
